// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the pixelate design (clock and reset port names assumed)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bap_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and reciprocal table for the block average pixelate design
package bap_pkg;

   localparam int PIX_W         = 8;
   localparam int LANES         = 4;
   localparam int LANE_W        = 16;
   localparam int SUM_W         = LANE_W * LANES;
   localparam int BLK_W         = 11;
   localparam int ROW_W         = 12;
   localparam int CFG_W         = 13;
   localparam int BS_W          = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int RECIP_W       = 23;
   localparam int RECIP_SHIFT   = 24;
   localparam int FIFO_DEPTH    = 4;
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_BLOCK = 16;

   localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [BS_W-1:0]  RST_BLOCK_SIZE   = 5'd2;
   localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd4096;
   localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;

   typedef struct packed {
      logic first;
      logic last;
   } flags_type;

   // ceil(2^24 / bs^2): exact truncated quotient for any 16-bit dividend
   function automatic logic [RECIP_W-1:0] recip(input logic [BS_W-1:0] bs);
      logic [RECIP_W-1:0] r;
      case (bs)
         5'd2:    r = 23'd4194304;
         5'd3:    r = 23'd1864136;
         5'd4:    r = 23'd1048576;
         5'd5:    r = 23'd671089;
         5'd6:    r = 23'd466034;
         5'd7:    r = 23'd342393;
         5'd8:    r = 23'd262144;
         5'd9:    r = 23'd207127;
         5'd10:   r = 23'd167773;
         5'd11:   r = 23'd138655;
         5'd12:   r = 23'd116509;
         5'd13:   r = 23'd99274;
         5'd14:   r = 23'd85599;
         5'd15:   r = 23'd74566;
         5'd16:   r = 23'd65536;
         default: r = 23'd4194304;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/bap_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters and pixel classification
`include "assert_macros.svh"

module bap_front #(
   parameter int MAX_WIDTH = bap_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bap_pkg::DEF_MAX_BLOCK
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bap_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bap_pkg::CFG_W-1:0]             csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bap_pkg::PIX_W-1:0]             req_red,
   input  logic [bap_pkg::PIX_W-1:0]             req_green,
   input  logic [bap_pkg::PIX_W-1:0]             req_blue,
   input  logic [bap_pkg::PIX_W-1:0]             req_alpha,
   input  logic                                  fifo_full,
   output logic                                  push,
   output logic [2 + bap_pkg::BLK_W + $clog2(MAX_WIDTH / 2) + 4 * bap_pkg::PIX_W - 1:0] push_data,
   output logic [bap_pkg::BS_W-1:0]              bs_eff
);

   localparam int PCOL_W = $clog2(MAX_WIDTH);
   localparam int ADDR_W = $clog2(MAX_WIDTH / 2);
   localparam int CIB_W  = $clog2(MAX_BLOCK);
   localparam int BsW    = bap_pkg::BS_W;
   localparam int CfgW   = bap_pkg::CFG_W;
   localparam int CmpW   = bap_pkg::CFG_W + 1;
   localparam int BlkW   = bap_pkg::BLK_W;
   localparam int RowW   = bap_pkg::ROW_W;
   localparam logic [CmpW-1:0] MaxW  = CmpW'(MAX_WIDTH);
   localparam logic [BsW-1:0]  MaxBs = BsW'(MAX_BLOCK);

   logic [BsW-1:0]    bs_ff;
   logic [CfgW-1:0]   iw_ff;
   logic [CfgW-1:0]   ih_ff;

   logic [PCOL_W-1:0] pcol_ff, pcol_in;
   logic [RowW-1:0]   prow_ff, prow_in;
   logic [CIB_W-1:0]  cib_ff, cib_in;
   logic [CIB_W-1:0]  rib_ff, rib_in;
   logic [ADDR_W-1:0] bcol_ff, bcol_in;
   logic [BlkW-1:0]   brow_ff, brow_in;

   logic              enabled;
   logic              accept;
   logic [CmpW-1:0]   iw_ext;
   logic [CmpW-1:0]   w_eff;
   logic [CfgW-1:0]   h_eff;
   logic              col_last;
   logic              row_last;
   logic              cib_last;
   logic              rib_last;
   bap_pkg::flags_type flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= bap_pkg::RST_BLOCK_SIZE;
         iw_ff <= bap_pkg::RST_IMAGE_WIDTH;
         ih_ff <= bap_pkg::RST_IMAGE_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            bap_pkg::CSR_BLOCK_SIZE:   bs_ff <= csr_wdata[BsW-1:0];
            bap_pkg::CSR_IMAGE_WIDTH:  iw_ff <= csr_wdata;
            bap_pkg::CSR_IMAGE_HEIGHT: ih_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign enabled = (bs_ff >= BsW'(2));
   assign bs_eff  = !enabled ? BsW'(2) : ((bs_ff > MaxBs) ? MaxBs : bs_ff);
   assign iw_ext  = {1'b0, iw_ff};
   assign w_eff   = (iw_ext < CmpW'(2)) ? CmpW'(2) : ((iw_ext > MaxW) ? MaxW : iw_ext);
   assign h_eff   = (ih_ff < CfgW'(2)) ? CfgW'(2)
                  : ((ih_ff > bap_pkg::MAX_HEIGHT) ? bap_pkg::MAX_HEIGHT : ih_ff);

   assign col_last = (CmpW'(pcol_ff) == w_eff - 1'b1);
   assign row_last = (CfgW'(prow_ff) == h_eff - 1'b1);
   assign cib_last = (BsW'(cib_ff) == bs_eff - 1'b1);
   assign rib_last = (BsW'(rib_ff) == bs_eff - 1'b1);

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && enabled;

   assign flags.first = (cib_ff == '0) && (rib_ff == '0);
   assign flags.last  = cib_last && rib_last;
   assign push_data   = {flags, brow_ff, bcol_ff, req_alpha, req_blue, req_green, req_red};

   always_comb begin
      pcol_in = pcol_ff;
      prow_in = prow_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      bcol_in = bcol_ff;
      brow_in = brow_ff;
      if (csr_we) begin
         pcol_in = '0;
         prow_in = '0;
         cib_in  = '0;
         rib_in  = '0;
         bcol_in = '0;
         brow_in = '0;
      end else if (accept) begin
         if (col_last) begin
            pcol_in = '0;
            cib_in  = '0;
            bcol_in = '0;
            if (row_last) begin
               prow_in = '0;
               rib_in  = '0;
               brow_in = '0;
            end else begin
               prow_in = prow_ff + 1'b1;
               if (enabled) begin
                  if (rib_last) begin
                     rib_in  = '0;
                     brow_in = brow_ff + 1'b1;
                  end else begin
                     rib_in = rib_ff + 1'b1;
                  end
               end
            end
         end else begin
            pcol_in = pcol_ff + 1'b1;
            if (enabled) begin
               if (cib_last) begin
                  cib_in  = '0;
                  bcol_in = bcol_ff + 1'b1;
               end else begin
                  cib_in = cib_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcol_ff <= '0;
         prow_ff <= '0;
         cib_ff  <= '0;
         rib_ff  <= '0;
         bcol_ff <= '0;
         brow_ff <= '0;
      end else begin
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
         cib_ff  <= cib_in;
         rib_ff  <= rib_in;
         bcol_ff <= bcol_in;
         brow_ff <= brow_in;
      end
   end

   `ASSERT_ALWAYS(a_cib_in_block, BsW'(cib_ff) < bs_eff, "column in block out of range")
   `ASSERT_ALWAYS(a_rib_in_block, BsW'(rib_ff) < bs_eff, "row in block out of range")

endmodule

// ===== hdl/bap_fifo.sv =====
`timescale 1ns / 1ps
// Small queue between the classifying front end and the accumulate/divide back end
`include "assert_macros.svh"

module bap_fifo #(
   parameter int WIDTH = 64,
   parameter int DEPTH = bap_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `ASSERT_IMPL(a_push_has_room, push, !full, "push into full queue")

endmodule

// ===== hdl/bap_back.sv =====
`timescale 1ns / 1ps
// Back end: per block column sum memory with read-modify-write, reciprocal divide, result register
`include "assert_macros.svh"

module bap_back #(
   parameter int MAX_WIDTH = bap_pkg::DEF_MAX_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fifo_empty,
   input  logic [2 + bap_pkg::BLK_W + $clog2(MAX_WIDTH / 2) + 4 * bap_pkg::PIX_W - 1:0] fifo_data,
   output logic                                  fifo_pop,
   input  logic [bap_pkg::BS_W-1:0]              bs_eff,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bap_pkg::BLK_W-1:0]             rsp_block_col,
   output logic [bap_pkg::BLK_W-1:0]             rsp_block_row,
   output logic [bap_pkg::PIX_W-1:0]             rsp_avg_red,
   output logic [bap_pkg::PIX_W-1:0]             rsp_avg_green,
   output logic [bap_pkg::PIX_W-1:0]             rsp_avg_blue,
   output logic [bap_pkg::PIX_W-1:0]             rsp_avg_alpha
);

   localparam int ADDR_W = $clog2(MAX_WIDTH / 2);
   localparam int DEPTH  = MAX_WIDTH / 2;
   localparam int PixW   = bap_pkg::PIX_W;
   localparam int LaneW  = bap_pkg::LANE_W;
   localparam int Lanes  = bap_pkg::LANES;
   localparam int SumW   = bap_pkg::SUM_W;
   localparam int BlkW   = bap_pkg::BLK_W;
   localparam int ProdW  = bap_pkg::LANE_W + bap_pkg::RECIP_W;

   bap_pkg::flags_type    hd_flags;
   logic [BlkW-1:0]       hd_brow;
   logic [ADDR_W-1:0]     hd_bcol;
   logic [Lanes*PixW-1:0] hd_pix;

   logic [SumW-1:0]       sums_mem [DEPTH];
   logic [SumW-1:0]       rd_data_ff;

   logic                  adv;
   logic                  wr_en;

   logic                  s1_valid_ff;
   bap_pkg::flags_type    s1_flags_ff;
   logic [BlkW-1:0]       s1_brow_ff;
   logic [ADDR_W-1:0]     s1_bcol_ff;
   logic [Lanes*PixW-1:0] s1_pix_ff;

   logic                  fwd_valid_ff;
   logic [ADDR_W-1:0]     fwd_addr_ff;
   logic [SumW-1:0]       fwd_data_ff;

   logic [SumW-1:0]       base;
   logic [LaneW-1:0]      pix_lane [Lanes];
   logic [SumW-1:0]       sum_new;

   logic                  s2_valid_ff;
   logic [BlkW-1:0]       s2_brow_ff;
   logic [ADDR_W-1:0]     s2_bcol_ff;
   logic [SumW-1:0]       s2_sum_ff;
   logic [bap_pkg::RECIP_W-1:0] recip;

   logic                  s3_valid_ff;
   logic [BlkW-1:0]       s3_brow_ff;
   logic [ADDR_W-1:0]     s3_bcol_ff;
   logic [ProdW-1:0]      s3_prod_ff [Lanes];

   logic                  rsp_valid_ff;
   logic [BlkW-1:0]       rsp_col_ff;
   logic [BlkW-1:0]       rsp_row_ff;
   logic [PixW-1:0]       rsp_avg_ff [Lanes];

   assign {hd_flags, hd_brow, hd_bcol, hd_pix} = fifo_data;

   // whole pipe moves whenever the result register can take a new entry
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign fifo_pop = adv && !fifo_empty;
   assign wr_en    = adv && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         rd_data_ff <= sums_mem[hd_bcol];
      end
      if (wr_en) begin
         sums_mem[s1_bcol_ff] <= sum_new;
      end
   end

   // last write bypasses the read that was taken at the same edge
   assign base = (fwd_valid_ff && (fwd_addr_ff == s1_bcol_ff)) ? fwd_data_ff : rd_data_ff;

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         pix_lane[k] = LaneW'(s1_pix_ff[k*PixW +: PixW]);
         sum_new[k*LaneW +: LaneW] = s1_flags_ff.first ? pix_lane[k]
                                   : base[k*LaneW +: LaneW] + pix_lane[k];
      end
   end

   assign recip = bap_pkg::recip(bs_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff  <= !fifo_empty;
            s2_valid_ff  <= s1_valid_ff && s1_flags_ff.last;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         s1_flags_ff <= hd_flags;
         s1_brow_ff  <= hd_brow;
         s1_bcol_ff  <= hd_bcol;
         s1_pix_ff   <= hd_pix;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_bcol_ff;
         fwd_data_ff <= sum_new;
      end
      if (adv) begin
         s2_brow_ff <= s1_brow_ff;
         s2_bcol_ff <= s1_bcol_ff;
         s2_sum_ff  <= sum_new;
         s3_brow_ff <= s2_brow_ff;
         s3_bcol_ff <= s2_bcol_ff;
         for (int k = 0; k < Lanes; k++) begin
            s3_prod_ff[k] <= ProdW'(s2_sum_ff[k*LaneW +: LaneW]) * ProdW'(recip);
            rsp_avg_ff[k] <= s3_prod_ff[k][bap_pkg::RECIP_SHIFT +: PixW];
         end
         rsp_col_ff <= BlkW'(s3_bcol_ff);
         rsp_row_ff <= s3_brow_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_col = rsp_col_ff;
   assign rsp_block_row = rsp_row_ff;
   assign rsp_avg_red   = rsp_avg_ff[0];
   assign rsp_avg_green = rsp_avg_ff[1];
   assign rsp_avg_blue  = rsp_avg_ff[2];
   assign rsp_avg_alpha = rsp_avg_ff[3];

   `ASSERT_NEXT(a_last_to_divide, adv && s1_valid_ff && s1_flags_ff.last, s2_valid_ff, "completed block lost before divide")

endmodule

// ===== hdl/block_average_pixelate.sv =====
`timescale 1ns / 1ps
// A block's last pixel goes to rsp_valid via the queue, s1, s2, s3 and result register.
// Throughput: one pixel per cycle while rsp_ready is high; the sum memory takes one read and
//   one write per cycle, with a write bypass for back-to-back columns.
// A waiting result stalls the back end; the front takes pixels until the 4-entry queue fills.
// Reset (synchronous, active high): block size 2, width and height 4096, counters and queue
//   cleared; block sums are not cleared and are overwritten by each block's first pixel.
module block_average_pixelate #(
   parameter int MAX_WIDTH = bap_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = bap_pkg::DEF_MAX_BLOCK
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bap_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bap_pkg::PIX_W-1:0]     req_red,
   input  logic [bap_pkg::PIX_W-1:0]     req_green,
   input  logic [bap_pkg::PIX_W-1:0]     req_blue,
   input  logic [bap_pkg::PIX_W-1:0]     req_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bap_pkg::BLK_W-1:0]     rsp_block_col,
   output logic [bap_pkg::BLK_W-1:0]     rsp_block_row,
   output logic [bap_pkg::PIX_W-1:0]     rsp_avg_red,
   output logic [bap_pkg::PIX_W-1:0]     rsp_avg_green,
   output logic [bap_pkg::PIX_W-1:0]     rsp_avg_blue,
   output logic [bap_pkg::PIX_W-1:0]     rsp_avg_alpha
);

   localparam int ITEM_W = 2 + bap_pkg::BLK_W + $clog2(MAX_WIDTH / 2) + 4 * bap_pkg::PIX_W;

   logic                        fifo_full;
   logic                        fifo_empty;
   logic                        push;
   logic                        pop;
   logic [ITEM_W-1:0]           push_data;
   logic [ITEM_W-1:0]           pop_data;
   logic [bap_pkg::BS_W-1:0]    bs_eff;

   bap_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .req_alpha (req_alpha),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data),
      .bs_eff    (bs_eff)
   );

   bap_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (bap_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   bap_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_empty),
      .fifo_data     (pop_data),
      .fifo_pop      (pop),
      .bs_eff        (bs_eff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_col (rsp_block_col),
      .rsp_block_row (rsp_block_row),
      .rsp_avg_red   (rsp_avg_red),
      .rsp_avg_green (rsp_avg_green),
      .rsp_avg_blue  (rsp_avg_blue),
      .rsp_avg_alpha (rsp_avg_alpha)
   );

endmodule

// ===== sim/tb_block_average_pixelate.sv =====
`timescale 1ns / 1ps
// Testbench for block_average_pixelate: random RGBA raster streams checked against predicted block means

typedef struct packed {
   logic [bap_pkg::BLK_W-1:0] col;
   logic [bap_pkg::BLK_W-1:0] row;
   logic [bap_pkg::PIX_W-1:0] red;
   logic [bap_pkg::PIX_W-1:0] green;
   logic [bap_pkg::PIX_W-1:0] blue;
   logic [bap_pkg::PIX_W-1:0] alpha;
} mosaic_block_type;

class mosaic_scoreboard;
   localparam int SUM_ENTRIES = bap_pkg::DEF_MAX_WIDTH / 2;

   logic [bap_pkg::SUM_W-1:0] block_sums [SUM_ENTRIES];
   logic [bap_pkg::BS_W-1:0]  block_size;
   logic [bap_pkg::CFG_W-1:0] image_width;
   logic [bap_pkg::CFG_W-1:0] image_height;
   int unsigned px_col, px_row, col_in_blk, row_in_blk, blk_col, blk_row;
   mosaic_block_type expected_blocks [$];
   int errors;

   function new();
      block_size   = bap_pkg::RST_BLOCK_SIZE;
      image_width  = bap_pkg::RST_IMAGE_WIDTH;
      image_height = bap_pkg::RST_IMAGE_HEIGHT;
      errors       = 0;
      restart_frame();
   endfunction

   function void restart_frame();
      px_col = 0;
      px_row = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      blk_col = 0;
      blk_row = 0;
   endfunction

   function void write_reg(input logic [bap_pkg::CSR_IDX_W-1:0] idx,
                           input logic [bap_pkg::CFG_W-1:0] data);
      case (idx)
         bap_pkg::CSR_BLOCK_SIZE:   block_size = data[bap_pkg::BS_W-1:0];
         bap_pkg::CSR_IMAGE_WIDTH:  image_width = data;
         bap_pkg::CSR_IMAGE_HEIGHT: image_height = data;
         default: ;
      endcase
      restart_frame();
   endfunction

   function int pending();
      return expected_blocks.size();
   endfunction

   function void add_pixel(input logic [7:0] r, g, b, a);
      bit enabled;
      int unsigned bs, w, h, area;
      logic [bap_pkg::SUM_W-1:0] pix, s;
      mosaic_block_type blk;
      enabled = block_size >= 2;
      bs = block_size < 2 ? 2 : (block_size > bap_pkg::DEF_MAX_BLOCK ?
                                 bap_pkg::DEF_MAX_BLOCK : block_size);
      w = image_width < 2 ? 2 : (image_width > bap_pkg::DEF_MAX_WIDTH ?
                                 bap_pkg::DEF_MAX_WIDTH : image_width);
      h = image_height < 2 ? 2 : (image_height > bap_pkg::MAX_HEIGHT ?
                                  bap_pkg::MAX_HEIGHT : image_height);
      if (enabled && blk_col < SUM_ENTRIES) begin
         pix = {8'd0, a, 8'd0, b, 8'd0, g, 8'd0, r};
         if (col_in_blk == 0 && row_in_blk == 0)
            block_sums[blk_col] = pix;
         else
            block_sums[blk_col] = block_sums[blk_col] + pix;
         if (col_in_blk == bs - 1 && row_in_blk == bs - 1) begin
            s = block_sums[blk_col];
            area = bs * bs;
            blk.col   = bap_pkg::BLK_W'(blk_col);
            blk.row   = bap_pkg::BLK_W'(blk_row);
            blk.red   = 8'(s[15:0] / area);
            blk.green = 8'(s[31:16] / area);
            blk.blue  = 8'(s[47:32] / area);
            blk.alpha = 8'(s[63:48] / area);
            expected_blocks.push_back(blk);
         end
      end
      px_col++;
      if (enabled) begin
         col_in_blk++;
         if (col_in_blk >= bs) begin
            col_in_blk = 0;
            blk_col++;
         end
      end
      if (px_col >= w) begin
         px_col = 0;
         col_in_blk = 0;
         blk_col = 0;
         px_row++;
         if (enabled) begin
            row_in_blk++;
            if (row_in_blk >= bs) begin
               row_in_blk = 0;
               blk_row++;
            end
         end
         if (px_row >= h) restart_frame();
      end
   endfunction

   task report(input string msg);
      if (errors < 50) $display("%s", msg);
      errors++;
   endtask

   task check_block(input mosaic_block_type got);
      mosaic_block_type want;
      if (expected_blocks.size() == 0) begin
         report($sformatf("unexpected block result: col %0d row %0d", got.col, got.row));
         return;
      end
      want = expected_blocks.pop_front();
      if (got.col != want.col || got.row != want.row || got.red != want.red ||
          got.green != want.green || got.blue != want.blue || got.alpha != want.alpha)
         report($sformatf({"block mismatch: got %0d,%0d rgba %0d %0d %0d %0d, ",
                           "expected %0d,%0d rgba %0d %0d %0d %0d"},
                          got.col, got.row, got.red, got.green, got.blue, got.alpha,
                          want.col, want.row, want.red, want.green, want.blue, want.alpha));
   endtask
endclass

module tb_block_average_pixelate;

   localparam logic [bap_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int LATENCY_PAD = 12;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [31:0] CORNER_PX [24] = '{
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'hFF00FF00, 32'h00FF00FF, 32'h01020304, 32'h80402010,
      32'hFF0000FF, 32'h00FFFF00, 32'hFE7F3F1F, 32'h01010101,
      32'h12345678, 32'h9ABCDEF0, 32'h55AA55AA, 32'hAA55AA55,
      32'h0F0F0F0F, 32'hF0F0F0F0, 32'h7F808180, 32'hC3C3C3C3
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [bap_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bap_pkg::CFG_W-1:0] csr_wdata;
   logic req_valid, req_ready;
   logic [bap_pkg::PIX_W-1:0] req_red, req_green, req_blue, req_alpha;
   logic rsp_valid, rsp_ready;
   logic [bap_pkg::BLK_W-1:0] rsp_block_col, rsp_block_row;
   logic [bap_pkg::PIX_W-1:0] rsp_avg_red, rsp_avg_green, rsp_avg_blue, rsp_avg_alpha;

   mosaic_scoreboard sb;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_off_cycles = 0;
   bit quiet = 1'b0;
   int cycle_count = 0;

   block_average_pixelate DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue), .req_alpha(req_alpha),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_block_col(rsp_block_col), .rsp_block_row(rsp_block_row),
      .rsp_avg_red(rsp_avg_red), .rsp_avg_green(rsp_avg_green),
      .rsp_avg_blue(rsp_avg_blue), .rsp_avg_alpha(rsp_avg_alpha)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // transfer monitor: note pixels, then check results
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid && req_ready)
            sb.add_pixel(req_red, req_green, req_blue, req_alpha);
         if (rsp_valid && rsp_ready)
            sb.check_block('{rsp_block_col, rsp_block_row, rsp_avg_red, rsp_avg_green,
                             rsp_avg_blue, rsp_avg_alpha});
      end
   end

   // result side: long hold-off on request, random stall bursts otherwise
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (!quiet && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 4))
         2:       return 10;
         3:       return 30;
         4:       return 60;
         default: return 0;
      endcase
   endfunction

   task automatic write_reg(input logic [bap_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bap_pkg::CFG_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [bap_pkg::CFG_W-1:0] bs_data, width, height);
      write_reg(bap_pkg::CSR_BLOCK_SIZE, bs_data);
      write_reg(bap_pkg::CSR_IMAGE_WIDTH, width);
      write_reg(bap_pkg::CSR_IMAGE_HEIGHT, height);
   endtask

   task automatic send_pixel(input logic [7:0] r, g, b, a);
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_alpha <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic stream_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
      end
   endtask

   task automatic drain_results(input int pad);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (pad) @(posedge clock);
   endtask

   task automatic run_phase(input logic [bap_pkg::CFG_W-1:0] bs_data, width, height,
                            input int count, input int gap, input int stall);
      set_frame(bs_data, width, height);
      gap_pct = gap;
      stall_pct = stall;
      stream_pixels(count);
      drain_results(LATENCY_PAD);
   endtask

   initial begin
      int random_items;
      int bsize, bs_eff, w, h, w_eff, h_eff, count;
      sb = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= bap_pkg::CSR_BLOCK_SIZE;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      req_alpha <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner values on a 4x4 frame, then into the next frame
      set_frame(13'd2, 13'd4, 13'd4);
      gap_pct = 30;
      stall_pct = 30;
      for (int i = 0; i < 24; i++)
         send_pixel(CORNER_PX[i][31:24], CORNER_PX[i][23:16], CORNER_PX[i][15:8],
                    CORNER_PX[i][7:0]);
      drain_results(LATENCY_PAD);

      // largest block, saturated sums
      set_frame(13'd16, 13'd16, 13'd16);
      for (int i = 0; i < 256; i++)
         send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drain_results(LATENCY_PAD);

      run_phase(13'd3, 13'd7, 13'd6, 100, 30, 30);
      run_phase(13'd0, 13'd5, 13'd5, 30, 10, 10);
      run_phase(13'd1, 13'd5, 13'd5, 20, 10, 10);
      run_phase(13'd31, 13'd20, 13'd16, 320, 10, 30);
      run_phase(13'h1FE2, 13'd0, 13'd1, 40, 30, 10);
      run_phase(13'd2, 13'd1, 13'd0, 20, 0, 60);
      // widest row, restarted mid-row by the next write
      run_phase(13'd2, 13'd8191, 13'd4096, 100, 10, 10);
      // tallest frame, height clamped
      run_phase(13'd2, 13'd2, 13'd8191, 100, 10, 10);

      // spare index restarts the frame with sums kept
      run_phase(13'd4, 13'd10, 13'd9, 57, 30, 30);
      write_reg(CSR_SPARE, 13'($urandom));
      stream_pixels(60);
      drain_results(LATENCY_PAD);

      // back-pressure: result side holds off while pixels keep coming
      set_frame(13'd2, 13'd4, 13'd64);
      gap_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 400;
      stream_pixels(100);
      drain_results(0);
      stream_pixels(50);
      drain_results(LATENCY_PAD);

      random_items = 0;
      while (random_items < 450) begin
         case ($urandom_range(0, 19))
            0:       bsize = $urandom_range(0, 1);
            1:       bsize = $urandom_range(17, 31);
            2, 3, 4: bsize = $urandom_range(8, 16);
            default: bsize = $urandom_range(2, 7);
         endcase
         bs_eff = bsize < 2 ? 2 : (bsize > bap_pkg::DEF_MAX_BLOCK ?
                                   bap_pkg::DEF_MAX_BLOCK : bsize);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
             $urandom_range(bs_eff, 3 * bs_eff + 5);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
             $urandom_range(bs_eff, 2 * bs_eff + 4);
         w_eff = w < 2 ? 2 : w;
         h_eff = h < 2 ? 2 : h;
         count = $urandom_range(1, 2 * w_eff * h_eff + w_eff);
         if (count > 250) count = 250;
         if (random_items >= 300) quiet = 1'b1;
         run_phase({8'($urandom), 5'(bsize)}, 13'(w), 13'(h), count, pick_pct(), pick_pct());
         random_items += count;
      end

      drain_results(LATENCY_PAD);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
